@@ design/address_range_membership_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the address range membership core
// Clocked property checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_MEMBERSHIP_CORE_ASSERT_SVH
`define ADDRESS_RANGE_MEMBERSHIP_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked at every rising edge outside reset.
`define ARC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define ARC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARC_ASSERT(lbl, clk, rst, prop, msg)
`define ARC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ design/arc_pkg.sv @@
// ----------------------------------------------------------------------------
// Address range membership package
// Sizes, item codes and the probe word that walks the chain of range cells.
// ----------------------------------------------------------------------------
`default_nettype none

package arc_pkg;

   localparam int MAX_RANGES = 64;
   localparam int ADDR_W     = 32;
   localparam int COUNT_W    = $clog2(MAX_RANGES + 1);

   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [ADDR_W-1:0] TALLY_MAX = {ADDR_W{1'b1}};

   // A query word in flight: the address and whether any cell so far held it.
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic              hit;
   } probe_type;

endpackage

`default_nettype wire

@@ design/address_range_membership_core.sv @@
// ----------------------------------------------------------------------------
// Address range membership core
// A row of range cells: adds insert at the head of the row, queries walk the
// row one cell per cycle unless held at its end, and leave with a covered flag and a running tally.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  mode, range_low, range_high, address
//  rsp      out        rsp_valid/rsp_stall  covered, covered_total, table_full
//
//  An add word's response is registered at the edge that accepts it.
//  A query word walks all MAX_RANGES cells, one per cycle unless rsp_stall
//  holds it at the end of the row; no new word is taken until its response
//  is registered.
//  Synchronous reset empties the table and clears the tally at once.
//  rsp_stall holds a query at the end of the row; an add is taken while a
//  response waits only if that response leaves in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module address_range_membership_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_mode,
   input  wire logic [arc_pkg::ADDR_W-1:0]    req_range_low,
   input  wire logic [arc_pkg::ADDR_W-1:0]    req_range_high,
   input  wire logic [arc_pkg::ADDR_W-1:0]    req_address,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_covered,
   output logic      [arc_pkg::ADDR_W-1:0]    rsp_covered_total,
   output logic                               rsp_table_full
);
   import arc_pkg::*;

   `include "address_range_membership_core_assert.svh"

   logic [COUNT_W-1:0] ranges_held_ff;
   logic [COUNT_W-1:0] ranges_held_in;
   logic [ADDR_W-1:0]  covered_tally_ff;
   logic [ADDR_W-1:0]  covered_tally_in;
   logic               busy_ff;
   logic               busy_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_covered_ff;
   logic               rsp_covered_in;
   logic [ADDR_W-1:0]  rsp_covered_total_ff;
   logic [ADDR_W-1:0]  rsp_covered_total_in;
   logic               rsp_table_full_ff;
   logic               rsp_table_full_in;

   logic               out_free;
   logic               req_fire;
   logic               add_fire;
   logic               query_fire;
   logic               table_has_room;
   logic               load_en;
   logic               exit_fire;
   logic               advance;
   probe_type          probe_head;
   probe_type          exit_probe;

   logic [ADDR_W-1:0]  low_chain   [MAX_RANGES];
   logic [ADDR_W-1:0]  high_chain  [MAX_RANGES];
   probe_type          probe_chain [MAX_RANGES];
   logic [MAX_RANGES-1:0] probe_valid;

   always_comb begin
      out_free       = !rsp_valid_ff || !rsp_stall;
      req_stall      = busy_ff || ((req_mode == MODE_ADD) && !out_free);
      req_fire       = req_valid && !req_stall;
      add_fire       = req_fire && (req_mode == MODE_ADD);
      query_fire     = req_fire && (req_mode == MODE_QUERY);
      table_has_room = ranges_held_ff < COUNT_W'(MAX_RANGES);
      load_en        = add_fire && table_has_room;
      exit_probe     = probe_chain[MAX_RANGES-1];
      exit_fire      = exit_probe.valid && out_free;
      advance        = !exit_probe.valid || out_free;

      probe_head.valid = query_fire;
      probe_head.addr  = req_address;
      probe_head.hit   = 1'b0;
   end

   // New ranges enter at cell zero and push older ones along, so the
   // occupied cells are always the first ranges_held of the row.
   for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
      logic [ADDR_W-1:0] prev_low;
      logic [ADDR_W-1:0] prev_high;
      probe_type         probe_prev;

      if (k == 0) begin : g_head
         assign prev_low   = req_range_low;
         assign prev_high  = req_range_high;
         assign probe_prev = probe_head;
      end else begin : g_body
         assign prev_low   = low_chain[k-1];
         assign prev_high  = high_chain[k-1];
         assign probe_prev = probe_chain[k-1];
      end

      arc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .load       (load_en),
         .occupied   (COUNT_W'(k) < ranges_held_ff),
         .prev_low   (prev_low),
         .prev_high  (prev_high),
         .probe_prev (probe_prev),
         .cell_low   (low_chain[k]),
         .cell_high  (high_chain[k]),
         .probe_out  (probe_chain[k])
      );

      assign probe_valid[k] = probe_chain[k].valid;
   end

   always_comb begin
      ranges_held_in   = load_en ? ranges_held_ff + COUNT_W'(1) : ranges_held_ff;

      covered_tally_in = covered_tally_ff;
      if (exit_fire && exit_probe.hit && (covered_tally_ff != TALLY_MAX)) begin
         covered_tally_in = covered_tally_ff + ADDR_W'(1);
      end

      busy_in = busy_ff;
      if (query_fire) begin
         busy_in = 1'b1;
      end else if (exit_fire) begin
         busy_in = 1'b0;
      end

      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_covered_in       = rsp_covered_ff;
      rsp_covered_total_in = rsp_covered_total_ff;
      rsp_table_full_in    = rsp_table_full_ff;
      if (exit_fire) begin
         rsp_valid_in         = 1'b1;
         rsp_covered_in       = exit_probe.hit;
         rsp_covered_total_in = covered_tally_in;
         rsp_table_full_in    = 1'b0;
      end else if (add_fire) begin
         rsp_valid_in         = 1'b1;
         rsp_covered_in       = 1'b0;
         rsp_covered_total_in = covered_tally_ff;
         rsp_table_full_in    = !table_has_room;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ranges_held_ff   <= '0;
         covered_tally_ff <= '0;
         busy_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         ranges_held_ff   <= ranges_held_in;
         covered_tally_ff <= covered_tally_in;
         busy_ff          <= busy_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_covered_ff       <= rsp_covered_in;
      rsp_covered_total_ff <= rsp_covered_total_in;
      rsp_table_full_ff    <= rsp_table_full_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_covered       = rsp_covered_ff;
   assign rsp_covered_total = rsp_covered_total_ff;
   assign rsp_table_full    = rsp_table_full_ff;

   `ARC_ASSERT(a_single_probe, clock, reset, $onehot0(probe_valid), "more than one query word")
   `ARC_ASSERT(a_probe_only_busy, clock, reset, |probe_valid |-> busy_ff, "query while idle")
   `ARC_ASSERT(a_count_bound, clock, reset, ranges_held_ff <= COUNT_W'(MAX_RANGES), "bad count")
   `ARC_ASSERT(a_tally_up, clock, reset, covered_tally_ff <= covered_tally_in, "tally went down")
   `ARC_ASSERT(a_flags, clock, reset, !(rsp_valid && rsp_covered && rsp_table_full), "two flags")
   `ARC_ASSERT_ALWAYS(a_reset, clock, $past(reset) |-> !rsp_valid_ff && !busy_ff, "not cleared")

endmodule

`default_nettype wire

@@ design/arc_cell.sv @@
// ----------------------------------------------------------------------------
// Range cell
// Holds one stored range, takes the range of its left neighbor when a new
// range is inserted, and passes a query word on with its own match folded in.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          load,
   input  wire logic                          occupied,
   input  wire logic [arc_pkg::ADDR_W-1:0]    prev_low,
   input  wire logic [arc_pkg::ADDR_W-1:0]    prev_high,
   input  wire arc_pkg::probe_type            probe_prev,
   output logic      [arc_pkg::ADDR_W-1:0]    cell_low,
   output logic      [arc_pkg::ADDR_W-1:0]    cell_high,
   output arc_pkg::probe_type                 probe_out
);
   import arc_pkg::*;

   logic [ADDR_W-1:0] low_ff;
   logic [ADDR_W-1:0] high_ff;
   probe_type         probe_ff;
   probe_type         probe_in;
   logic              hit_here;

   // An inverted range cannot pass both compares at once and so never matches.
   always_comb begin
      hit_here       = occupied && (low_ff <= probe_prev.addr)
                       && (probe_prev.addr <= high_ff);
      probe_in       = probe_prev;
      probe_in.hit   = probe_prev.hit | hit_here;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         low_ff  <= prev_low;
         high_ff <= prev_high;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else if (advance) begin
         probe_ff <= probe_in;
      end
   end

   assign cell_low  = low_ff;
   assign cell_high = high_ff;
   assign probe_out = probe_ff;

endmodule

`default_nettype wire
